FILE: design/h264rtp_pkg.sv
// ----------------------------------------------------------------------------
// H.264 RTP packetizer package
// Shared types, constants and helpers for the packetizer sequencer and its
// arithmetic unit.
// ----------------------------------------------------------------------------
package h264rtp_pkg;

    localparam int LEN_W  = 16;
    localparam int SIZE_W = 14;
    localparam int BYTE_W = 8;
    localparam int ALU_W  = 17;

    localparam logic [SIZE_W-1:0] HEADER_BYTES = 14'd12;
    localparam logic [SIZE_W-1:0] TARGET_MIN   = 14'd1100;
    localparam logic [SIZE_W-1:0] TARGET_MAX   = 14'd9000;
    localparam logic [SIZE_W-1:0] TARGET_RESET = 14'd1400;
    // header plus FU indicator and FU header
    localparam logic [SIZE_W-1:0] FU_OVERHEAD  = 14'd14;

    localparam logic [BYTE_W-1:0] STAP_A_TYPE = 8'd24;
    localparam logic [BYTE_W-1:0] FU_A_TYPE   = 8'd28;
    localparam logic [BYTE_W-1:0] NRI_MASK    = 8'he0;
    localparam logic [BYTE_W-1:0] TYPE_MASK   = 8'h1f;

    // small addends fed to the shared adder
    localparam logic [3:0] K_ZERO      = 4'd0;
    localparam logic [3:0] K_STAP_LEN  = 4'd2;
    localparam logic [3:0] K_HDR       = 4'd12;
    localparam logic [3:0] K_STAP_OPEN = 4'd15;

    typedef enum logic [2:0] {
        SEG_CLOSE     = 3'd0,
        SEG_SINGLE    = 3'd1,
        SEG_STAP_FIRST = 3'd2,
        SEG_STAP_ADD  = 3'd3,
        SEG_FU_A      = 3'd4
    } t_seg_type;

    typedef struct packed {
        t_seg_type          seg_type;
        logic               packet_start;
        logic [BYTE_W-1:0]  prefix_first;
        logic [BYTE_W-1:0]  prefix_second;
        logic [LEN_W-1:0]   src_offset;
        logic [LEN_W-1:0]   copy_len;
        logic               packet_end;
        logic [SIZE_W-1:0]  payload_len;
        logic [BYTE_W-1:0]  packet_priority;
        logic [BYTE_W-1:0]  packet_importance;
        logic               marker;
        logic               last;
    } t_seg;

    typedef struct packed {
        logic [SIZE_W-1:0] maxs;
        logic [SIZE_W-1:0] three_quarter;
        logic [SIZE_W-1:0] room;
    } t_limits;

    typedef struct packed {
        logic [ALU_W-1:0] a;
        logic [ALU_W-1:0] b;
        logic [3:0]       k;
        logic             sub;
        logic [ALU_W-1:0] c;
    } t_alu_req;

    typedef struct packed {
        logic [ALU_W-1:0] res;
        logic             lt;
        logic             eq;
    } t_alu_rsp;

    function automatic logic [BYTE_W-1:0] umin8(input logic [BYTE_W-1:0] x,
                                                input logic [BYTE_W-1:0] y);
        umin8 = (y < x) ? y : x;
    endfunction

    function automatic logic [SIZE_W-1:0] pay_len(input logic [SIZE_W-1:0] fill);
        pay_len = fill - HEADER_BYTES;
    endfunction

endpackage

FILE: design/h264rtp_if.sv
// ----------------------------------------------------------------------------
// H.264 RTP packetizer channels
// NAL unit descriptor channel and segment descriptor channel, valid/ready.
// ----------------------------------------------------------------------------
interface h264rtp_nalu_if;
    import h264rtp_pkg::*;

    logic              valid;
    logic              ready;
    logic [LEN_W-1:0]  nalu_len;
    logic [BYTE_W-1:0] nalu_header;
    logic [BYTE_W-1:0] priority_req;
    logic [BYTE_W-1:0] importance;
    logic              frame_end;

    modport source (output valid, nalu_len, nalu_header, priority_req, importance,
                    frame_end, input ready);
    modport sink   (input valid, nalu_len, nalu_header, priority_req, importance,
                    frame_end, output ready);
endinterface

interface h264rtp_seg_if;
    import h264rtp_pkg::*;

    logic              valid;
    logic              ready;
    t_seg_type         seg_type;
    logic              packet_start;
    logic [BYTE_W-1:0] prefix_first;
    logic [BYTE_W-1:0] prefix_second;
    logic [LEN_W-1:0]  src_offset;
    logic [LEN_W-1:0]  copy_len;
    logic              packet_end;
    logic [SIZE_W-1:0] payload_len;
    logic [BYTE_W-1:0] packet_priority;
    logic [BYTE_W-1:0] packet_importance;
    logic              marker;
    logic              last;

    modport source (output valid, seg_type, packet_start, prefix_first, prefix_second,
                    src_offset, copy_len, packet_end, payload_len, packet_priority,
                    packet_importance, marker, last, input ready);
    modport sink   (input valid, seg_type, packet_start, prefix_first, prefix_second,
                    src_offset, copy_len, packet_end, payload_len, packet_priority,
                    packet_importance, marker, last, output ready);
endinterface

FILE: design/h264rtp_alu.sv
// ----------------------------------------------------------------------------
// Packetizer arithmetic unit
// Shared add/subtract with small constant addend and unsigned compare.
// ----------------------------------------------------------------------------
module h264rtp_alu (
    input  h264rtp_pkg::t_alu_req i_req,
    output h264rtp_pkg::t_alu_rsp o_rsp
);
    import h264rtp_pkg::*;

    logic [ALU_W-1:0] b_eff;
    logic [ALU_W-1:0] sum;

    // subtract as a + ~b + 1
    assign b_eff = i_req.sub ? ~i_req.b : i_req.b;
    assign sum   = i_req.a + b_eff + ALU_W'(i_req.k) + ALU_W'(i_req.sub);

    assign o_rsp.res = sum;
    assign o_rsp.lt  = (sum < i_req.c);
    assign o_rsp.eq  = (sum == i_req.c);

endmodule

FILE: design/h264rtp_seq.sv
// ----------------------------------------------------------------------------
// Packetizer sequencer
// Steps one NAL unit through the fit checks and the FU-A fragment loop on the
// shared arithmetic unit, and holds the open packet and the output register.
// ----------------------------------------------------------------------------
module h264rtp_seq (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  h264rtp_pkg::t_limits  i_lim,
    h264rtp_nalu_if.sink          i_nalu,
    h264rtp_seg_if.source         o_seg,
    output h264rtp_pkg::t_alu_req o_alu_req,
    input  h264rtp_pkg::t_alu_rsp i_alu_rsp
);
    import h264rtp_pkg::*;

    typedef enum logic [6:0] {
        S_IDLE = 7'b0000001,
        S_AGG  = 7'b0000010,
        S_TQ   = 7'b0000100,
        S_MX3  = 7'b0001000,
        S_SGL  = 7'b0010000,
        S_FRAG = 7'b0100000,
        S_ADV  = 7'b1000000
    } t_state;

    t_state r_state, n_state;

    // item under work
    logic [LEN_W-1:0]  r_len;
    logic [BYTE_W-1:0] r_hdr, r_pr, r_im;
    logic              r_fend;

    // open packet
    logic              r_open, n_open;
    logic [SIZE_W-1:0] r_fill, n_fill;
    logic [BYTE_W-1:0] r_opr, n_opr, r_oim, n_oim;

    // fragment loop
    logic [LEN_W-1:0]  r_off, n_off;
    logic [SIZE_W-1:0] r_flen, n_flen;
    logic              r_first, n_first;
    logic              r_tq_ok, n_tq_ok;

    // output register
    logic              r_ovalid;
    t_seg              r_out, n_res;
    logic              emit;
    logic              slot_free;

    logic              accept;
    logic              fit;
    logic [SIZE_W-1:0] flen;
    logic [SIZE_W-1:0] new_fill;
    logic [BYTE_W-1:0] min_pr, min_im;

    assign accept    = i_nalu.valid && i_nalu.ready;
    assign slot_free = !r_ovalid || o_seg.ready;
    assign i_nalu.ready = (r_state == S_IDLE);

    assign fit      = i_alu_rsp.lt || i_alu_rsp.eq;
    assign flen     = fit ? i_alu_rsp.res[SIZE_W-1:0] : i_lim.room;
    assign new_fill = i_alu_rsp.res[SIZE_W-1:0];
    assign min_pr   = umin8(r_opr, r_pr);
    assign min_im   = umin8(r_oim, r_im);

    always_comb begin
        n_state   = r_state;
        n_open    = r_open;
        n_fill    = r_fill;
        n_opr     = r_opr;
        n_oim     = r_oim;
        n_off     = r_off;
        n_flen    = r_flen;
        n_first   = r_first;
        n_tq_ok   = r_tq_ok;
        emit      = 1'b0;
        n_res     = '0;
        o_alu_req = '0;

        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_state = S_AGG;
                end
            end
            S_AGG: begin
                o_alu_req.a = ALU_W'(r_fill);
                o_alu_req.b = ALU_W'(r_len);
                o_alu_req.k = K_STAP_LEN;
                o_alu_req.c = ALU_W'(i_lim.maxs);
                if (r_open && i_alu_rsp.lt) begin
                    if (slot_free) begin
                        emit               = 1'b1;
                        n_res.seg_type     = SEG_STAP_ADD;
                        n_res.copy_len     = r_len;
                        n_res.last         = 1'b1;
                        if (r_fend) begin
                            n_res.packet_end        = 1'b1;
                            n_res.payload_len       = pay_len(new_fill);
                            n_res.packet_priority   = min_pr;
                            n_res.packet_importance = min_im;
                            n_res.marker            = 1'b1;
                            n_open = 1'b0;
                            n_fill = '0;
                        end else begin
                            n_fill = new_fill;
                        end
                        n_opr   = min_pr;
                        n_oim   = min_im;
                        n_state = S_IDLE;
                    end
                end else if (r_open) begin
                    // evict the open packet first
                    if (slot_free) begin
                        emit                    = 1'b1;
                        n_res.seg_type          = SEG_CLOSE;
                        n_res.packet_end        = 1'b1;
                        n_res.payload_len       = pay_len(r_fill);
                        n_res.packet_priority   = r_opr;
                        n_res.packet_importance = r_oim;
                        n_open  = 1'b0;
                        n_fill  = '0;
                        n_state = S_TQ;
                    end
                end else begin
                    n_state = S_TQ;
                end
            end
            S_TQ: begin
                o_alu_req.a = ALU_W'(r_len);
                o_alu_req.k = K_HDR;
                o_alu_req.c = ALU_W'(i_lim.three_quarter);
                n_tq_ok = i_alu_rsp.lt;
                n_state = S_MX3;
            end
            S_MX3: begin
                o_alu_req.a = ALU_W'(r_len);
                o_alu_req.k = K_STAP_OPEN;
                o_alu_req.c = ALU_W'(i_lim.maxs);
                if (r_tq_ok && i_alu_rsp.lt) begin
                    if (slot_free) begin
                        emit               = 1'b1;
                        n_res.seg_type     = SEG_STAP_FIRST;
                        n_res.packet_start = 1'b1;
                        n_res.prefix_first = STAP_A_TYPE;
                        n_res.copy_len     = r_len;
                        n_res.last         = 1'b1;
                        if (r_fend) begin
                            n_res.packet_end        = 1'b1;
                            n_res.payload_len       = pay_len(new_fill);
                            n_res.packet_priority   = r_pr;
                            n_res.packet_importance = r_im;
                            n_res.marker            = 1'b1;
                        end else begin
                            n_open = 1'b1;
                            n_fill = new_fill;
                        end
                        n_opr   = r_pr;
                        n_oim   = r_im;
                        n_state = S_IDLE;
                    end
                end else begin
                    n_state = S_SGL;
                end
            end
            S_SGL: begin
                o_alu_req.a = ALU_W'(r_len);
                o_alu_req.k = K_HDR;
                o_alu_req.c = ALU_W'(i_lim.maxs);
                if (fit) begin
                    if (slot_free) begin
                        emit                    = 1'b1;
                        n_res.seg_type          = SEG_SINGLE;
                        n_res.packet_start      = 1'b1;
                        n_res.copy_len          = r_len;
                        n_res.packet_end        = 1'b1;
                        n_res.payload_len       = r_len[SIZE_W-1:0];
                        n_res.packet_priority   = r_pr;
                        n_res.packet_importance = r_im;
                        n_res.marker            = r_fend;
                        n_res.last              = 1'b1;
                        n_state = S_IDLE;
                    end
                end else begin
                    n_off   = LEN_W'(1);
                    n_first = 1'b1;
                    n_state = S_FRAG;
                end
            end
            S_FRAG: begin
                // remaining bytes against the fragment room
                o_alu_req.a   = ALU_W'(r_len);
                o_alu_req.b   = ALU_W'(r_off);
                o_alu_req.sub = 1'b1;
                o_alu_req.c   = ALU_W'(i_lim.room);
                if (slot_free) begin
                    emit                    = 1'b1;
                    n_res.seg_type          = SEG_FU_A;
                    n_res.packet_start      = 1'b1;
                    n_res.prefix_first      = (r_hdr & NRI_MASK) | FU_A_TYPE;
                    n_res.prefix_second     = {r_first, fit, 1'b0, 5'b0} |
                                              (r_hdr & TYPE_MASK);
                    n_res.src_offset        = r_off;
                    n_res.copy_len          = LEN_W'(flen);
                    n_res.packet_end        = 1'b1;
                    n_res.payload_len       = flen + SIZE_W'(2);
                    n_res.packet_priority   = r_pr;
                    n_res.packet_importance = r_im;
                    n_res.marker            = r_fend && fit;
                    n_res.last              = fit;
                    n_flen  = flen;
                    n_first = 1'b0;
                    n_state = fit ? S_IDLE : S_ADV;
                end
            end
            S_ADV: begin
                o_alu_req.a = ALU_W'(r_off);
                o_alu_req.b = ALU_W'(r_flen);
                n_off   = i_alu_rsp.res[LEN_W-1:0];
                n_state = S_FRAG;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_open   <= 1'b0;
            r_fill   <= '0;
            r_opr    <= '0;
            r_oim    <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_open  <= n_open;
            r_fill  <= n_fill;
            r_opr   <= n_opr;
            r_oim   <= n_oim;
            if (emit) begin
                r_ovalid <= 1'b1;
            end else if (o_seg.ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_len  <= i_nalu.nalu_len;
            r_hdr  <= i_nalu.nalu_header;
            r_pr   <= i_nalu.priority_req;
            r_im   <= i_nalu.importance;
            r_fend <= i_nalu.frame_end;
        end
        if (emit) begin
            r_out <= n_res;
        end
        r_off   <= n_off;
        r_flen  <= n_flen;
        r_first <= n_first;
        r_tq_ok <= n_tq_ok;
    end

    assign o_seg.valid             = r_ovalid;
    assign o_seg.seg_type          = r_out.seg_type;
    assign o_seg.packet_start      = r_out.packet_start;
    assign o_seg.prefix_first      = r_out.prefix_first;
    assign o_seg.prefix_second     = r_out.prefix_second;
    assign o_seg.src_offset        = r_out.src_offset;
    assign o_seg.copy_len          = r_out.copy_len;
    assign o_seg.packet_end        = r_out.packet_end;
    assign o_seg.payload_len       = r_out.payload_len;
    assign o_seg.packet_priority   = r_out.packet_priority;
    assign o_seg.packet_importance = r_out.packet_importance;
    assign o_seg.marker            = r_out.marker;
    assign o_seg.last              = r_out.last;

    a_open_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_open |-> (r_fill >= HEADER_BYTES + 14'd3))
        else $error("open packet with fill below STAP-A minimum");

    a_closed_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_open |-> (r_fill == '0))
        else $error("closed packet keeps a fill position");

    a_frag_off: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FRAG) |-> (r_off < r_len))
        else $error("fragment offset past end of NAL unit");

    a_accept_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> (r_state == S_AGG))
        else $error("accepted beat not taken to fit check");

    a_fu_closes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ovalid && r_out.seg_type == SEG_FU_A) |-> r_out.packet_end)
        else $error("FU-A segment does not close its packet");

endmodule

FILE: design/h264_rtp_packetizer.sv
// ----------------------------------------------------------------------------
// H.264 RTP packetizer
// Turns NAL unit descriptors into single NAL, STAP-A and FU-A copy commands.
// ----------------------------------------------------------------------------
// Sequence: an accepted item goes to the fit check (S_AGG), which appends it to the
//   open STAP-A or evicts that packet; a new STAP-A then passes S_TQ and S_MX3, a
//   single NAL also S_SGL, and FU-A also S_FRAG, with S_ADV between fragments. An
//   output stall holds any emitting step; one shared adder sets this order.
// Throughput: one item at a time; ready returns once the last result is loaded.
// Reset: synchronous active-low; no open packet, target size 1400.
module h264_rtp_packetizer (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [h264rtp_pkg::SIZE_W-1:0] i_cfg_wdata,
    h264rtp_nalu_if.sink                  i_nalu,
    h264rtp_seg_if.source                 o_seg
);
    import h264rtp_pkg::*;

    logic [SIZE_W-1:0] r_target;
    logic [SIZE_W-1:0] maxs;
    logic [SIZE_W+1:0] three_maxs;
    t_limits           lim;
    t_alu_req          alu_req;
    t_alu_rsp          alu_rsp;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_target <= TARGET_RESET;
        end else if (i_cfg_we) begin
            r_target <= i_cfg_wdata;
        end
    end

    // saturate the target, then derive the STAP-A and FU-A limits
    always_comb begin
        if (r_target < TARGET_MIN) begin
            maxs = TARGET_MIN;
        end else if (r_target > TARGET_MAX) begin
            maxs = TARGET_MAX;
        end else begin
            maxs = r_target;
        end
        three_maxs        = {2'b00, maxs} + {1'b0, maxs, 1'b0};
        lim.maxs          = maxs;
        lim.three_quarter = three_maxs[SIZE_W+1:2];
        lim.room          = maxs - FU_OVERHEAD;
    end

    h264rtp_seq u_seq (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_lim     (lim),
        .i_nalu    (i_nalu),
        .o_seg     (o_seg),
        .o_alu_req (alu_req),
        .i_alu_rsp (alu_rsp)
    );

    h264rtp_alu u_alu (
        .i_req (alu_req),
        .o_rsp (alu_rsp)
    );

endmodule
